// ===== hw/rtl/sfdl_pkg.sv =====
// Shared types and constants for the stereo fractional delay line.
// Used by the lane, merge and top-level modules and by its port checker; depends on nothing.
package sfdl_pkg;

    // Fixed field widths of the stream and register ports
    localparam int DELAY_IN_W      = 40;
    localparam int DEFAULT_DELAY_W = 32;
    localparam int MAX_DELAY_W     = 16;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_DELAY = 1'b1;

    // Register reset values
    localparam int                         MAX_DELAY_RESET     = 48000;
    localparam logic [DEFAULT_DELAY_W-1:0] DEFAULT_DELAY_RESET = '0;

    // Command codes
    localparam logic CMD_PROCESS = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;

    // Output queue sizing; it also bounds the beats in flight
    localparam int OUT_FIFO_DEPTH = 8;
    localparam int OUT_PTR_W      = 3;
    localparam int OUT_CNT_W      = 4;

    // Per-beat tap control handed from the front end to each channel lane
    typedef struct packed {
        logic clear;     // clear command: force a zero result
        logic use_cur;   // whole delay is zero: tap a is the current sample
        logic a_live;    // tap a entry written since the last clear
        logic b_live;    // tap b entry written since the last clear
        logic wr_en;     // store the current sample into the ring
    } t_tap_flags;

endpackage

// ===== hw/rtl/sfdl_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module sfdl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, and read both ports into output registers
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== hw/rtl/sfdl_lane.sv =====
// One channel lane: history ring, tap selection, difference, multiply and blend.
// Depends on sfdl_pkg and sfdl_ram.
module sfdl_lane #(
    parameter int RING_DEPTH  = 65536,
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  sfdl_pkg::t_tap_flags          i_flags,
    input  logic [$clog2(RING_DEPTH)-1:0] i_addr_a,
    input  logic [$clog2(RING_DEPTH)-1:0] i_addr_b,
    input  logic [$clog2(RING_DEPTH)-1:0] i_wr_addr,
    input  logic [SAMPLE_BITS-1:0]        i_cur,
    input  logic [FRAC_BITS-1:0]          i_frac,
    output logic                          o_vld,
    output logic [SAMPLE_BITS-1:0]        o_sample
);

    localparam int DW = SAMPLE_BITS + 1;
    localparam int PW = SAMPLE_BITS + FRAC_BITS + 2;

    logic [SAMPLE_BITS-1:0] ram_a;
    logic [SAMPLE_BITS-1:0] ram_b;

    sfdl_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk    (i_clk),
        .i_we     (i_flags.wr_en),
        .i_waddr  (i_wr_addr),
        .i_wdata  (i_cur),
        .i_raddr_a(i_addr_a),
        .i_raddr_b(i_addr_b),
        .o_rdata_a(ram_a),
        .o_rdata_b(ram_b)
    );

    // Hold control alongside the ring read
    logic                   r_c_vld;
    sfdl_pkg::t_tap_flags   r_c_flags;
    logic [SAMPLE_BITS-1:0] r_c_cur;
    logic [FRAC_BITS-1:0]   r_c_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= i_vld;
        end
        r_c_flags <= i_flags;
        r_c_cur   <= i_cur;
        r_c_frac  <= i_frac;
    end

    // Select taps; unwritten entries read as zero
    logic signed [SAMPLE_BITS-1:0] tap_a;
    logic signed [SAMPLE_BITS-1:0] tap_b;
    logic signed [DW-1:0]          n_d_diff;

    always_comb begin
        if (r_c_flags.clear) begin
            tap_a = '0;
        end else if (r_c_flags.use_cur) begin
            tap_a = r_c_cur;
        end else if (r_c_flags.a_live) begin
            tap_a = ram_a;
        end else begin
            tap_a = '0;
        end
        if (!r_c_flags.clear && r_c_flags.b_live) begin
            tap_b = ram_b;
        end else begin
            tap_b = '0;
        end
        n_d_diff = DW'(tap_b) - DW'(tap_a);
    end

    logic                          r_d_vld;
    logic signed [SAMPLE_BITS-1:0] r_d_a;
    logic signed [DW-1:0]          r_d_diff;
    logic [FRAC_BITS-1:0]          r_d_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
        r_d_a    <= tap_a;
        r_d_diff <= n_d_diff;
        r_d_frac <= r_c_frac;
    end

    // Weight the difference by the fraction
    logic signed [FRAC_BITS:0] frac_s;
    logic signed [PW-1:0]      n_e_prod;

    assign frac_s   = $signed({1'b0, r_d_frac});
    assign n_e_prod = PW'(r_d_diff) * PW'(frac_s);

    logic                   r_e_vld;
    logic [SAMPLE_BITS-1:0] r_e_a;
    logic signed [PW-1:0]   r_e_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= r_d_vld;
        end
        r_e_a    <= r_d_a;
        r_e_prod <= n_e_prod;
    end

    // Floor shift and add back tap a; keep the low sample bits
    logic signed [PW-1:0]   prod_sh;
    logic [SAMPLE_BITS-1:0] n_sample;

    assign prod_sh  = r_e_prod >>> FRAC_BITS;
    assign n_sample = r_e_a + prod_sh[SAMPLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= r_e_vld;
        end
        o_sample <= n_sample;
    end

endmodule

// ===== hw/rtl/sfdl_merge.sv =====
// Merge stage: pairs the left and right lane results into one output beat
// and queues them for the consumer. Depends on sfdl_pkg.
module sfdl_merge #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_left_vld,
    input  logic                   i_right_vld,
    input  logic [SAMPLE_BITS-1:0] i_left,
    input  logic [SAMPLE_BITS-1:0] i_right,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [SAMPLE_BITS-1:0] o_left,
    output logic [SAMPLE_BITS-1:0] o_right
);

    logic [SAMPLE_BITS-1:0]     r_left_q  [sfdl_pkg::OUT_FIFO_DEPTH];
    logic [SAMPLE_BITS-1:0]     r_right_q [sfdl_pkg::OUT_FIFO_DEPTH];
    logic [sfdl_pkg::OUT_PTR_W-1:0] r_wr_ptr;
    logic [sfdl_pkg::OUT_PTR_W-1:0] r_rd_ptr;
    logic [sfdl_pkg::OUT_CNT_W-1:0] r_count;

    logic push;
    logic pop;

    // Both lanes run in lockstep; a beat is complete when both report
    assign push    = i_left_vld & i_right_vld;
    assign o_valid = (r_count != '0);
    assign pop     = o_valid & i_ready;
    assign o_left  = r_left_q[r_rd_ptr];
    assign o_right = r_right_q[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + sfdl_pkg::OUT_CNT_W'(push)
                               - sfdl_pkg::OUT_CNT_W'(pop);
        end
    end

    // Store the paired samples
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_left_q[r_wr_ptr]  <= i_left;
            r_right_q[r_wr_ptr] <= i_right;
        end
    end

endmodule

// ===== hw/rtl/stereo_fractional_delay_line.sv =====
// Stereo fractional delay line with linear interpolation. Each beat carries one stereo
// frame and a Q23.16 delay (or uses the default delay register); the delay is clamped
// to 0..max_delay_frames and each channel returns x[n-k] blended toward x[n-k-1] by the
// fraction. The block takes one beat per clock cycle when the consumer keeps up; a result
// passes through the clamp register, the registered ring read, the difference, multiply
// and blend registers and the output queue. The two history rings are dual-read RAMs,
// one per lane, with the ring write done in the same cycle as the tap reads. At most eight
// beats are outstanding (in the pipeline or waiting in the output queue); ready drops at
// that limit. A clear command or a write of max_delay_frames takes effect at once through
// a fill count, with no clearing pass; entries not written since then read as zero.
// Depends on sfdl_pkg, sfdl_lane, sfdl_merge.
module stereo_fractional_delay_line #(
    parameter int RING_DEPTH  = 65536,
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [sfdl_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [sfdl_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    // input stream
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_command,
    input  logic signed [SAMPLE_BITS-1:0]         i_left_in,
    input  logic signed [SAMPLE_BITS-1:0]         i_right_in,
    input  logic signed [sfdl_pkg::DELAY_IN_W-1:0] i_delay_frames,
    input  logic                                  i_delay_present,
    // output stream
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [SAMPLE_BITS-1:0]         o_left_out,
    output logic signed [SAMPLE_BITS-1:0]         o_right_out
);

    localparam int AW     = $clog2(RING_DEPTH);
    localparam int CMP_W  = (AW > sfdl_pkg::MAX_DELAY_W) ? AW : sfdl_pkg::MAX_DELAY_W;
    localparam int DCMP_W = (AW + FRAC_BITS > sfdl_pkg::DELAY_IN_W)
                            ? AW + FRAC_BITS : sfdl_pkg::DELAY_IN_W;
    localparam int RST_DMAX = (sfdl_pkg::MAX_DELAY_RESET > RING_DEPTH - 1)
                              ? RING_DEPTH - 1 : sfdl_pkg::MAX_DELAY_RESET;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [AW-1:0]                          r_dmax;
    logic [AW:0]                            r_len;
    logic [sfdl_pkg::DEFAULT_DELAY_W-1:0]   r_default_delay;
    logic [CMP_W-1:0]                       cfg_max;
    logic [CMP_W-1:0]                       cfg_dmax;
    logic                                   cfg_ring_clear;

    // Limit the maximum to the ring size
    always_comb begin
        cfg_max = CMP_W'(i_cfg_wdata[sfdl_pkg::MAX_DELAY_W-1:0]);
        if (cfg_max > CMP_W'(RING_DEPTH - 1)) begin
            cfg_dmax = CMP_W'(RING_DEPTH - 1);
        end else begin
            cfg_dmax = cfg_max;
        end
    end

    assign cfg_ring_clear = i_cfg_we && (i_cfg_idx == sfdl_pkg::CFG_MAX_DELAY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dmax          <= AW'(RST_DMAX);
            r_len           <= (AW + 1)'(RST_DMAX + 1);
            r_default_delay <= sfdl_pkg::DEFAULT_DELAY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sfdl_pkg::CFG_MAX_DELAY: begin
                    r_dmax <= cfg_dmax[AW-1:0];
                    r_len  <= {1'b0, cfg_dmax[AW-1:0]} + 1'b1;
                end
                sfdl_pkg::CFG_DEFAULT_DELAY: begin
                    r_default_delay <= i_cfg_wdata[sfdl_pkg::DEFAULT_DELAY_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Flow control: count beats accepted but not yet delivered
    // ---------------------------------------------------------------
    logic                           accept;
    logic                           deliver;
    logic [sfdl_pkg::OUT_CNT_W-1:0] r_inflight;

    assign o_ready = (r_inflight != sfdl_pkg::OUT_CNT_W'(sfdl_pkg::OUT_FIFO_DEPTH));
    assign accept  = i_valid & o_ready;
    assign deliver = o_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + sfdl_pkg::OUT_CNT_W'(accept)
                                     - sfdl_pkg::OUT_CNT_W'(deliver);
        end
    end

    // ---------------------------------------------------------------
    // Stage A: clamp the delay and split it into whole and fraction
    // ---------------------------------------------------------------
    logic [DCMP_W-1:0] d_req;
    logic [DCMP_W-1:0] d_max_fix;
    logic [DCMP_W-1:0] d_clamp;

    always_comb begin
        if (i_delay_present) begin
            if (i_delay_frames[sfdl_pkg::DELAY_IN_W-1]) begin
                d_req = '0;
            end else begin
                d_req = DCMP_W'(i_delay_frames[sfdl_pkg::DELAY_IN_W-2:0]);
            end
        end else begin
            d_req = DCMP_W'(r_default_delay);
        end
        d_max_fix = DCMP_W'({r_dmax, {FRAC_BITS{1'b0}}});
        if (d_req > d_max_fix) begin
            d_clamp = d_max_fix;
        end else begin
            d_clamp = d_req;
        end
    end

    logic                   r_a_vld;
    logic                   r_a_clear;
    logic [SAMPLE_BITS-1:0] r_a_left;
    logic [SAMPLE_BITS-1:0] r_a_right;
    logic [AW-1:0]          r_a_k;
    logic [FRAC_BITS-1:0]   r_a_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= accept;
        end
        r_a_clear <= (i_command == sfdl_pkg::CMD_CLEAR);
        r_a_left  <= i_left_in;
        r_a_right <= i_right_in;
        r_a_k     <= d_clamp[FRAC_BITS +: AW];
        r_a_frac  <= d_clamp[FRAC_BITS-1:0];
    end

    // ---------------------------------------------------------------
    // Stage B: ring addresses, liveness and write position
    // ---------------------------------------------------------------
    logic [AW-1:0]        r_wp;
    logic [AW:0]          r_fill;
    logic [AW:0]          t_a;
    logic [AW:0]          t_b;
    logic [AW:0]          t_a_wrap;
    logic [AW:0]          t_b_wrap;
    logic [AW-1:0]        addr_a;
    logic [AW-1:0]        addr_b;
    logic [AW:0]          wp_inc;
    sfdl_pkg::t_tap_flags flags;

    always_comb begin
        t_a      = {1'b0, r_wp} - {1'b0, r_a_k};
        t_b      = t_a - 1'b1;
        t_a_wrap = t_a + r_len;
        t_b_wrap = t_b + r_len;
        addr_a   = t_a[AW] ? t_a_wrap[AW-1:0] : t_a[AW-1:0];
        addr_b   = t_b[AW] ? t_b_wrap[AW-1:0] : t_b[AW-1:0];
        wp_inc   = {1'b0, r_wp} + 1'b1;

        flags.clear   = r_a_clear;
        flags.use_cur = (r_a_k == '0);
        flags.a_live  = ({1'b0, addr_a} < r_fill);
        flags.b_live  = ({1'b0, addr_b} < r_fill);
        flags.wr_en   = r_a_vld & ~r_a_clear;
    end

    // Advance the write position, or reset it on a clear; the fill count saturates at the ring length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_ring_clear) begin
            r_wp   <= '0;
            r_fill <= '0;
        end else if (r_a_vld) begin
            if (r_a_clear) begin
                r_wp   <= '0;
                r_fill <= '0;
            end else begin
                r_wp <= (wp_inc == r_len) ? '0 : wp_inc[AW-1:0];
                if (r_fill != r_len) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Channel lanes
    // ---------------------------------------------------------------
    logic                   left_vld;
    logic                   right_vld;
    logic [SAMPLE_BITS-1:0] left_sample;
    logic [SAMPLE_BITS-1:0] right_sample;

    sfdl_lane #(
        .RING_DEPTH (RING_DEPTH),
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_lane_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_a_vld),
        .i_flags  (flags),
        .i_addr_a (addr_a),
        .i_addr_b (addr_b),
        .i_wr_addr(r_wp),
        .i_cur    (r_a_left),
        .i_frac   (r_a_frac),
        .o_vld    (left_vld),
        .o_sample (left_sample)
    );

    sfdl_lane #(
        .RING_DEPTH (RING_DEPTH),
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_lane_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_a_vld),
        .i_flags  (flags),
        .i_addr_a (addr_a),
        .i_addr_b (addr_b),
        .i_wr_addr(r_wp),
        .i_cur    (r_a_right),
        .i_frac   (r_a_frac),
        .o_vld    (right_vld),
        .o_sample (right_sample)
    );

    // ---------------------------------------------------------------
    // Merge and queue the stereo result
    // ---------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] out_left;
    logic [SAMPLE_BITS-1:0] out_right;

    sfdl_merge #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_left_vld (left_vld),
        .i_right_vld(right_vld),
        .i_left     (left_sample),
        .i_right    (right_sample),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_left     (out_left),
        .o_right    (out_right)
    );

    assign o_left_out  = out_left;
    assign o_right_out = out_right;

endmodule

// ===== hw/rtl/sfdl_checker.sv =====
// Port-level checker for the stereo fractional delay line, bound to the top level.
// Depends on sfdl_pkg and on the top level's ports.
module sfdl_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_ready,
    input logic                   o_valid,
    input logic                   i_ready,
    input logic [SAMPLE_BITS-1:0] o_left_out,
    input logic [SAMPLE_BITS-1:0] o_right_out
);

    logic [sfdl_pkg::OUT_CNT_W-1:0] r_open;
    logic                           in_beat;
    logic                           out_beat;

    assign in_beat  = i_valid & o_ready;
    assign out_beat = o_valid & i_ready;

    // Track beats accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + sfdl_pkg::OUT_CNT_W'(in_beat)
                             - sfdl_pkg::OUT_CNT_W'(out_beat);
        end
    end

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_left_out) && $stable(o_right_out))
        else $error("output beat changed while stalled");

    // Every result belongs to an accepted beat
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_open != '0)
        else $error("output beat without a pending input beat");

    // Ready is withheld exactly at the outstanding limit
    a_ready_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (r_open != sfdl_pkg::OUT_CNT_W'(sfdl_pkg::OUT_FIFO_DEPTH)))
        else $error("ready does not match outstanding beat count");

    // Nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

endmodule

bind stereo_fractional_delay_line sfdl_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_sfdl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_left_out (o_left_out),
    .o_right_out(o_right_out)
);
